>>> hdl/bdll_pkg.sv
// Shared types and constants for the bounded doubly linked list engine.
`timescale 1ns / 1ps

package bdll_pkg;

    // Pool size and stored value width
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;

    // Node index width and link width (a link also holds the null code)
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LNK_W = $clog2(CAPACITY + 1);
    localparam logic [LNK_W-1:0] NIL = LNK_W'(CAPACITY);

    // Stream field widths
    localparam int KIND_W   = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 7;
    localparam int STAT_W   = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 4'd0,
        K_INS_BACK  = 4'd1,
        K_INS_POS   = 4'd2,
        K_DEL_FRONT = 4'd3,
        K_DEL_BACK  = 4'd4,
        K_DEL_POS   = 4'd5,
        K_LENGTH    = 4'd6,
        K_REVERSE   = 4'd7,
        K_READ_OUT  = 4'd8
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_BAD_POS  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_WT,
        S_SUCC_RD,
        S_SUCC_WT,
        S_ALLOC,
        S_ALLOC_WT,
        S_INS_W1,
        S_INS_W2,
        S_DEL_RD,
        S_DEL_WT,
        S_DEL_W1,
        S_DEL_W2,
        S_RO_RD,
        S_RO_WT,
        S_RESP
    } t_state;

endpackage

>>> hdl/bdll_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bdll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/bounded_doubly_linked_list.sv
// Bounded doubly linked list engine: command sequencer over three node memories.
`timescale 1ns / 1ps

// One command is taken at a time; o_s_axis_tready is high only while the engine
// is idle. Positional insert and delete walk the links with one registered read
// of the link memory per link. Read out gives one beat per element when the
// output is not stalled. No clearing pass is needed after reset: fresh nodes
// are handed out by a fill counter, freed ones are recycled through a free list
// held in the next links. Results go through an output register, so a finished
// beat may wait on the master side while the engine already takes the next
// command.
module bounded_doubly_linked_list (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command beats
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  logic [bdll_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [3:0] kind
    input  logic [bdll_pkg::KIND_W-1:0]     i_s_axis_tuser,
    // result beats
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [31:0] value_res, [38:32] length, [39] zero
    output logic [bdll_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [bdll_pkg::STAT_W-1:0]     o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);

    import bdll_pkg::*;

    // Control state
    t_state           r_state, n_state;
    logic [LNK_W-1:0] r_head, n_head;
    logic [LNK_W-1:0] r_tail, n_tail;
    logic [LNK_W-1:0] r_count, n_count;
    logic [LNK_W-1:0] r_free, n_free;
    logic [LNK_W-1:0] r_fill, n_fill;
    logic             r_orient, n_orient;
    logic             r_ovalid, n_ovalid;

    // Working registers
    t_kind             r_kind, n_kind;
    logic [LNK_W-1:0]  r_cur, n_cur;
    logic [LNK_W-1:0]  r_p, n_p;
    logic [LNK_W-1:0]  r_s, n_s;
    logic [LNK_W-1:0]  r_new, n_new;
    logic [LNK_W-1:0]  r_steps, n_steps;
    logic [LNK_W-1:0]  r_left, n_left;
    logic [VALUE_BITS-1:0] r_val, n_val;
    t_status           r_st, n_st;
    logic [DATA_W-1:0] r_rv, n_rv;

    // Output register
    logic [OUT_TDATA_W-1:0] r_odata, n_odata;
    t_status                r_ouser, n_ouser;
    logic                   r_olast, n_olast;

    // Memory ports
    logic                  val_we, nx_we, pv_we, val_re, lk_re;
    logic [IDX_W-1:0]      val_waddr, nx_waddr, pv_waddr, lk_raddr;
    logic [VALUE_BITS-1:0] val_wdata, val_rdata;
    logic [LNK_W-1:0]      nx_wdata, pv_wdata, nx_rdata, pv_rdata;
    logic [LNK_W-1:0]      f_rdata, b_rdata;

    // Logical forward / backward writes, mapped by orientation
    logic             f_we, b_we, free_we;
    logic [LNK_W-1:0] f_addr, f_data, b_addr, b_data;

    // Command decode helpers
    t_kind                in_kind;
    logic [POS_W-1:0]     in_pos;
    logic [LNK_W:0]       pos_x, cnt_x;
    logic                 in_acc, slot_free;

    assign in_kind   = t_kind'(i_s_axis_tuser);
    assign in_pos    = i_s_axis_tdata[POS_W-1:0];
    assign pos_x     = (LNK_W+1)'(in_pos);
    assign cnt_x     = (LNK_W+1)'(r_count);
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign slot_free = !r_ovalid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

    // Forward and backward link as seen through the orientation
    assign f_rdata = r_orient ? pv_rdata : nx_rdata;
    assign b_rdata = r_orient ? nx_rdata : pv_rdata;

    // Node memories
    bdll_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val (
        .i_clk  (i_clk),
        .i_we   (val_we),
        .i_waddr(val_waddr),
        .i_wdata(val_wdata),
        .i_re   (val_re),
        .i_raddr(r_cur[IDX_W-1:0]),
        .o_rdata(val_rdata)
    );

    bdll_ram #(.WIDTH(LNK_W), .DEPTH(CAPACITY)) u_next (
        .i_clk  (i_clk),
        .i_we   (nx_we),
        .i_waddr(nx_waddr),
        .i_wdata(nx_wdata),
        .i_re   (lk_re),
        .i_raddr(lk_raddr),
        .o_rdata(nx_rdata)
    );

    bdll_ram #(.WIDTH(LNK_W), .DEPTH(CAPACITY)) u_prev (
        .i_clk  (i_clk),
        .i_we   (pv_we),
        .i_waddr(pv_waddr),
        .i_wdata(pv_wdata),
        .i_re   (lk_re),
        .i_raddr(lk_raddr),
        .o_rdata(pv_rdata)
    );

    // Map logical link writes onto the physical memories
    always_comb begin
        if (free_we) begin
            nx_we    = 1'b1;
            nx_waddr = r_cur[IDX_W-1:0];
            nx_wdata = r_free;
        end else if (r_orient) begin
            nx_we    = b_we;
            nx_waddr = b_addr[IDX_W-1:0];
            nx_wdata = b_data;
        end else begin
            nx_we    = f_we;
            nx_waddr = f_addr[IDX_W-1:0];
            nx_wdata = f_data;
        end
        if (r_orient) begin
            pv_we    = f_we;
            pv_waddr = f_addr[IDX_W-1:0];
            pv_wdata = f_data;
        end else begin
            pv_we    = b_we;
            pv_waddr = b_addr[IDX_W-1:0];
            pv_wdata = b_data;
        end
    end

    // Sequencer: reads and writes never hit the same cycle, so no forwarding
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_free   = r_free;
        n_fill   = r_fill;
        n_orient = r_orient;
        n_kind   = r_kind;
        n_cur    = r_cur;
        n_p      = r_p;
        n_s      = r_s;
        n_new    = r_new;
        n_steps  = r_steps;
        n_left   = r_left;
        n_val    = r_val;
        n_st     = r_st;
        n_rv     = r_rv;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_odata  = r_odata;
        n_ouser  = r_ouser;
        n_olast  = r_olast;

        val_we    = 1'b0;
        val_waddr = r_new[IDX_W-1:0];
        val_wdata = r_val;
        val_re    = 1'b0;
        lk_re     = 1'b0;
        lk_raddr  = r_cur[IDX_W-1:0];
        f_we      = 1'b0;
        f_addr    = r_p;
        f_data    = r_s;
        b_we      = 1'b0;
        b_addr    = r_s;
        b_data    = r_p;
        free_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = in_kind;
                    n_val  = VALUE_BITS'(i_s_axis_tdata[POS_W +: DATA_W]);
                    n_st   = ST_OK;
                    n_rv   = '0;
                    n_cur  = r_head;
                    n_state = S_RESP;
                    case (in_kind) inside
                        K_INS_FRONT: begin
                            if (r_count == NIL) begin
                                n_st = ST_FULL;
                            end else begin
                                n_p = NIL;
                                n_s = r_head;
                                n_state = S_ALLOC;
                            end
                        end
                        K_INS_BACK: begin
                            if (r_count == NIL) begin
                                n_st = ST_FULL;
                            end else begin
                                n_p = r_tail;
                                n_s = NIL;
                                n_state = S_ALLOC;
                            end
                        end
                        K_INS_POS: begin
                            if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                                n_st = ST_BAD_POS;
                            end else if (r_count == NIL) begin
                                n_st = ST_FULL;
                            end else if (pos_x == (LNK_W+1)'(1)) begin
                                n_p = NIL;
                                n_s = r_head;
                                n_state = S_ALLOC;
                            end else if (pos_x == cnt_x + 1'b1) begin
                                n_p = r_tail;
                                n_s = NIL;
                                n_state = S_ALLOC;
                            end else begin
                                // walk to the node before the position
                                n_steps = LNK_W'(pos_x - 2'd2);
                                n_state = (pos_x == (LNK_W+1)'(2)) ? S_SUCC_RD : S_WALK_RD;
                            end
                        end
                        K_DEL_FRONT, K_DEL_BACK: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_cur = (in_kind == K_DEL_FRONT) ? r_head : r_tail;
                                n_state = S_DEL_RD;
                            end
                        end
                        K_DEL_POS: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else if (pos_x == '0 || pos_x > cnt_x) begin
                                n_st = ST_BAD_POS;
                            end else begin
                                n_steps = LNK_W'(pos_x - 1'b1);
                                n_state = (pos_x == (LNK_W+1)'(1)) ? S_DEL_RD : S_WALK_RD;
                            end
                        end
                        K_LENGTH: begin
                            if (r_count == '0) n_st = ST_EMPTY;
                        end
                        K_REVERSE: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_head   = r_tail;
                                n_tail   = r_head;
                                n_orient = !r_orient;
                            end
                        end
                        K_READ_OUT: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_left  = r_count;
                                n_state = S_RO_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // walk the links, one registered read per link
            S_WALK_RD: begin
                lk_re   = 1'b1;
                n_state = S_WALK_WT;
            end
            S_WALK_WT: begin
                n_cur   = f_rdata;
                n_steps = r_steps - 1'b1;
                if (r_steps == LNK_W'(1)) begin
                    n_state = (r_kind == K_INS_POS) ? S_SUCC_RD : S_DEL_RD;
                end else begin
                    n_state = S_WALK_RD;
                end
            end

            // successor of the insert point
            S_SUCC_RD: begin
                lk_re   = 1'b1;
                n_state = S_SUCC_WT;
            end
            S_SUCC_WT: begin
                n_p     = r_cur;
                n_s     = f_rdata;
                n_state = S_ALLOC;
            end

            // take a node: recycled one first, else a fresh one
            S_ALLOC: begin
                lk_re    = (r_free != NIL);
                lk_raddr = r_free[IDX_W-1:0];
                n_state  = S_ALLOC_WT;
            end
            S_ALLOC_WT: begin
                if (r_free != NIL) begin
                    n_new  = r_free;
                    n_free = nx_rdata;
                end else begin
                    n_new  = r_fill;
                    n_fill = r_fill + 1'b1;
                end
                n_state = S_INS_W1;
            end
            S_INS_W1: begin
                val_we  = 1'b1;
                f_we    = 1'b1;
                f_addr  = r_new;
                f_data  = r_s;
                b_we    = 1'b1;
                b_addr  = r_new;
                b_data  = r_p;
                n_state = S_INS_W2;
            end
            S_INS_W2: begin
                f_we   = (r_p != NIL);
                f_addr = r_p;
                f_data = r_new;
                b_we   = (r_s != NIL);
                b_addr = r_s;
                b_data = r_new;
                if (r_p == NIL) n_head = r_new;
                if (r_s == NIL) n_tail = r_new;
                n_count = r_count + 1'b1;
                n_state = S_RESP;
            end

            // unlink the node at r_cur
            S_DEL_RD: begin
                val_re  = 1'b1;
                lk_re   = 1'b1;
                n_state = S_DEL_WT;
            end
            S_DEL_WT: begin
                n_p     = b_rdata;
                n_s     = f_rdata;
                n_rv    = DATA_W'(val_rdata);
                n_state = S_DEL_W1;
            end
            S_DEL_W1: begin
                f_we   = (r_p != NIL);
                f_addr = r_p;
                f_data = r_s;
                b_we   = (r_s != NIL);
                b_addr = r_s;
                b_data = r_p;
                if (r_p == NIL) n_head = r_s;
                if (r_s == NIL) n_tail = r_p;
                // count drops together with head and tail
                n_count = r_count - 1'b1;
                n_state = S_DEL_W2;
            end
            S_DEL_W2: begin
                free_we = 1'b1;
                n_free  = r_cur;
                n_state = S_RESP;
            end

            // read out front to back
            S_RO_RD: begin
                val_re  = 1'b1;
                lk_re   = 1'b1;
                n_state = S_RO_WT;
            end
            S_RO_WT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = OUT_TDATA_W'({LEN_W'(r_count), DATA_W'(val_rdata)});
                    n_ouser  = ST_OK;
                    n_olast  = (r_left == LNK_W'(1));
                    n_cur    = f_rdata;
                    n_left   = r_left - 1'b1;
                    n_state  = (r_left == LNK_W'(1)) ? S_IDLE : S_RO_RD;
                end
            end

            S_RESP: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = OUT_TDATA_W'({LEN_W'(r_count), r_rv});
                    n_ouser  = r_st;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= NIL;
            r_tail   <= NIL;
            r_count  <= '0;
            r_free   <= NIL;
            r_fill   <= '0;
            r_orient <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_free   <= n_free;
            r_fill   <= n_fill;
            r_orient <= n_orient;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and output payload registers
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_cur   <= n_cur;
        r_p     <= n_p;
        r_s     <= n_s;
        r_new   <= n_new;
        r_steps <= n_steps;
        r_left  <= n_left;
        r_val   <= n_val;
        r_st    <= n_st;
        r_rv    <= n_rv;
        r_odata <= n_odata;
        r_ouser <= n_ouser;
        r_olast <= n_olast;
    end

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NIL)
        else $error("element count above capacity");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NIL) == (r_count == '0))
        else $error("head null does not match empty list");

    a_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tail == NIL) == (r_count == '0))
        else $error("tail null does not match empty list");

    a_fill_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_fill)
        else $error("more elements than nodes ever handed out");

    a_ro_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RO_WT) |-> (r_left != '0))
        else $error("read out past the last element");

endmodule
